>>> rtl/psbc_pkg.sv
// Package: shared types and constants of the printable six-bit codec.
`default_nettype none
package psbc_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-1:0] RegModeAddr = 3'd0;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [7:0] CharBias = 8'd33;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
    logic [1:0] tail_bytes;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_t;

  // One completed group handed from the gatherer to the emitter
  typedef struct packed {
    logic            load;
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
  } grp_t;

endpackage
`default_nettype wire

>>> rtl/psbc_cfg.sv
// Module: APB register file holding the codec mode.
`default_nettype none
module psbc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psbc_pkg::AddrW-1:0]   paddr,
  input  wire logic [psbc_pkg::DataW-1:0]   pwdata,
  output logic      [psbc_pkg::DataW-1:0]   prdata,
  output logic                              pready,
  output logic                              mode_o
);

  logic mode_q, mode_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == psbc_pkg::RegModeAddr);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= psbc_pkg::ModeEncode;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == psbc_pkg::RegModeAddr) begin
      prdata = {{(psbc_pkg::DataW-1){1'b0}}, mode_q};
    end
  end

  assign mode_o = mode_q;

endmodule
`default_nettype wire

>>> rtl/psbc_gather.sv
// Module: collects input items into groups and forms the encoded or decoded group.
`default_nettype none
module psbc_gather (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_i,
  input  wire logic          in_valid_i,
  input  wire psbc_pkg::in_t in_data_i,
  output logic               in_stall_o,
  input  wire logic          grp_ready_i,
  output psbc_pkg::grp_t     grp_o
);

  logic [1:0]      fill_q, fill_d;
  logic [2:0][7:0] held_q, held_d;
  logic            produces, accept;
  logic [7:0]      a, b, c, e0, e1, e2, e3, d;
  logic            lst;
  logic [1:0]      tail;

  assign d    = in_data_i.data_in;
  assign lst  = in_data_i.last_in;
  assign tail = in_data_i.tail_bytes;

  always_comb begin
    if (mode_i == psbc_pkg::ModeEncode) begin
      produces = (fill_q >= 2'd2) || lst;
    end else begin
      produces = (fill_q == 2'd3);
    end
  end

  assign in_stall_o = produces && !grp_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // encode operands
  always_comb begin
    if (fill_q >= 2'd2) begin
      a = held_q[0];
      b = held_q[1];
      c = d;
    end else begin
      a = (fill_q == 2'd0) ? d : held_q[0];
      b = (fill_q == 2'd1) ? d : 8'd0;
      c = 8'd0;
    end
  end

  assign e0 = held_q[0] - psbc_pkg::CharBias;
  assign e1 = held_q[1] - psbc_pkg::CharBias;
  assign e2 = held_q[2] - psbc_pkg::CharBias;
  assign e3 = d - psbc_pkg::CharBias;

  always_comb begin
    grp_o.load = accept && produces;
    if (mode_i == psbc_pkg::ModeEncode) begin
      grp_o.bytes[0] = psbc_pkg::CharBias + {2'b00, a[7:2]};
      grp_o.bytes[1] = psbc_pkg::CharBias + {2'b00, a[1:0], b[7:4]};
      grp_o.bytes[2] = psbc_pkg::CharBias + {2'b00, b[3:0], c[7:6]};
      grp_o.bytes[3] = psbc_pkg::CharBias + {2'b00, c[5:0]};
      grp_o.count    = 3'd4;
      grp_o.last     = lst;
    end else begin
      grp_o.bytes[0] = (e0 << 2) | (e1 >> 4);
      grp_o.bytes[1] = (e1 << 4) | (e2 >> 2);
      grp_o.bytes[2] = (e2 << 6) | e3;
      grp_o.bytes[3] = 8'd0;
      grp_o.count    = (lst && (tail != 2'd0)) ? {1'b0, tail} : 3'd3;
      grp_o.last     = lst;
    end
  end

  always_comb begin
    fill_d = fill_q;
    held_d = held_q;
    if (accept) begin
      if (produces || lst) begin
        fill_d = 2'd0;
      end else begin
        fill_d = fill_q + 2'd1;
        case (fill_q)
          2'd0:    held_d[0] = d;
          2'd1:    held_d[1] = d;
          2'd2:    held_d[2] = d;
          default: held_d    = held_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      held_q <= '0;
    end else begin
      fill_q <= fill_d;
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/psbc_emit.sv
// Module: result register for one group; sends one item per cycle unless stalled.
`default_nettype none
module psbc_emit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire psbc_pkg::grp_t grp_i,
  output logic                grp_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output psbc_pkg::out_t      out_data_o
);

  logic [3:0][7:0] bytes_q, bytes_d;
  logic [2:0]      rem_q, rem_d;
  logic [1:0]      idx_q, idx_d;
  logic            last_q, last_d;
  logic            out_xfer;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign grp_ready_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_xfer);

  assign out_data_o.data_out = bytes_q[idx_q];
  assign out_data_o.last_out = last_q && (rem_q == 3'd1);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    last_d  = last_q;
    if (out_xfer) begin
      rem_d = rem_q - 3'd1;
      idx_d = idx_q + 2'd1;
    end
    if (grp_i.load) begin
      bytes_d = grp_i.bytes;
      rem_d   = grp_i.count;
      idx_d   = 2'd0;
      last_d  = grp_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 3'd0;
      idx_q  <= 2'd0;
      last_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      idx_q  <= idx_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule
`default_nettype wire

>>> rtl/printable_six_bit_codec.sv
// Top level: printable six-bit codec (3 bytes <-> 4 printable characters).
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one byte or
// character per transfer with last_in and tail_bytes. Output channel
// (out_valid_o / out_stall_i / out_data_o) carries one result per transfer.
// The mode register (APB, address 0) picks encode (0) or decode (1); write it
// only while the codec is idle.
// Items that only fill a group are taken every cycle. The item that completes
// a group loads the result register at that edge; its first result is valid
// the next cycle, then one result per cycle while the receiver does not
// stall. An encoded group is 4 results, a decoded group 1 to 3. The register
// drains one item per cycle when not stalled, so encoding sustains three input
// transfers per four results, decoding one per cycle. A completing item is
// stalled while the result register still holds a result that does not leave
// at that edge. When the receiver stalls, the shown result holds until taken.
// Reset sets encode mode and clears the group fill and the result count.
`default_nettype none
module printable_six_bit_codec (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire psbc_pkg::in_t                in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output psbc_pkg::out_t                    out_data_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [psbc_pkg::AddrW-1:0]   paddr,
  input  wire logic [psbc_pkg::DataW-1:0]   pwdata,
  output logic      [psbc_pkg::DataW-1:0]   prdata,
  output logic                              pready
);

  logic           mode;
  logic           grp_ready;
  psbc_pkg::grp_t grp;

  psbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  psbc_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  psbc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
